### src/time_window_slot_assigner_defines.svh
// Assertion helpers for the slot assigner.
`ifndef TIME_WINDOW_SLOT_ASSIGNER_DEFINES_SVH
`define TIME_WINDOW_SLOT_ASSIGNER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TWSA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TWSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/twsa_pkg.sv
package twsa_pkg;

	localparam int NUM_SLOTS = 512;
	localparam int MAX_FREQS = 1024;

	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int TIME_W    = 64;
	localparam int FREQ_W    = 10;
	localparam int SEQ_W     = 64;
	localparam int NFREQ_W   = 11;
	localparam int SLOT_O_W  = 9;
	localparam int ADDR_W    = 19;
	localparam int WCNT_W    = 32;
	localparam int PROD_W    = SLOT_W + NFREQ_W + 1;

	localparam int IN_BITS   = TIME_W + FREQ_W + SEQ_W;
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = SLOT_O_W + ADDR_W + SEQ_W + 1 + WCNT_W;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
	localparam int USER_W    = 2;

	localparam logic [NFREQ_W-1:0] NFREQ_RST = NFREQ_W'(MAX_FREQS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_CMP,
		ST_FINISH
	} state_t;

	typedef enum logic [USER_W-1:0] {
		OUT_WRITTEN = 2'd0,
		OUT_OOO     = 2'd1,
		OUT_LATE    = 2'd2
	} outcome_t;

	// One probe of the binary search.
	typedef struct packed {
		logic             eq;
		logic             lt;
		logic [CNT_W-1:0] next_lo;
		logic [CNT_W-1:0] next_hi;
		logic             done;
	} srch_res_t;

	// (a + b) mod NUM_SLOTS for a < NUM_SLOTS, b <= NUM_SLOTS.
	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
		input logic [SLOT_W:0] b);
		logic [SLOT_W+1:0] sum;
		sum = {2'b00, a} + {1'b0, b};
		if (sum >= (SLOT_W+2)'(NUM_SLOTS))
			sum = sum - (SLOT_W+2)'(NUM_SLOTS);
		return sum[SLOT_W-1:0];
	endfunction

endpackage

### src/time_window_slot_assigner.sv
// Each input word is placed by a binary search over the held times in P probes,
//   P <= ceil(log2(held+1)), at most 10 with 512 slots held; P = 0 when empty.
// Each probe has two steps: address issue, then compare on the registered RAM read.
// One word is worked on at a time; the next input is taken once the result
//   sits in the output register, even if the sink has not yet taken it.
// Reset (arst_n low, async): ring empty, newest slot 0, write count 0, num_freqs 1024.
`include "time_window_slot_assigner_defines.svh"

module time_window_slot_assigner (
	input  logic                          clk,
	input  logic                          arst_n,
	// config: num_freqs
	input  logic                          cfg_we,
	input  logic [twsa_pkg::NFREQ_W-1:0]  cfg_wdata,
	// input word
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [63:0] timestamp, [73:64] freq_index, [137:74] sequence_value, rest zero
	input  logic [twsa_pkg::IN_W-1:0]     s_axis_tdata,
	// result word
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [8:0] slot, [27:9] record_address, [91:28] record_value,
	// [92] slot_cleared, [124:93] write_count, rest zero
	output logic [twsa_pkg::OUT_W-1:0]    m_axis_tdata,
	// [1:0] outcome
	output logic [twsa_pkg::USER_W-1:0]   m_axis_tuser
);

	localparam int N = twsa_pkg::NUM_SLOTS;

	twsa_pkg::state_t state_q, state_d;

	// architectural state
	logic [twsa_pkg::CNT_W-1:0]   held_q;
	logic [twsa_pkg::SLOT_W-1:0]  newest_q;
	logic [twsa_pkg::WCNT_W-1:0]  wcnt_q;
	logic [twsa_pkg::NFREQ_W-1:0] nfreq_q;

	// captured word
	logic [twsa_pkg::TIME_W-1:0]  key_q;
	logic [twsa_pkg::FREQ_W-1:0]  freq_q;
	logic [twsa_pkg::SEQ_W-1:0]   seq_q;

	// search state
	logic [twsa_pkg::CNT_W-1:0]   lo_q, hi_q;
	logic [twsa_pkg::SLOT_W-1:0]  oldest_q;
	logic [twsa_pkg::SLOT_W-1:0]  probe_slot_q;
	logic                         found_q;
	logic [twsa_pkg::SLOT_W-1:0]  found_slot_q;

	// output register
	logic                         m_valid_q;
	twsa_pkg::outcome_t           o_outcome_q;
	logic [twsa_pkg::SLOT_O_W-1:0] o_slot_q;
	logic [twsa_pkg::ADDR_W-1:0]  o_addr_q;
	logic [twsa_pkg::SEQ_W-1:0]   o_val_q;
	logic                         o_clr_q;
	logic [twsa_pkg::WCNT_W-1:0]  o_wcnt_q;

	// sequencer outputs
	logic in_take, ram_re, out_load;

	// shared probe unit
	logic [twsa_pkg::SLOT_W-1:0]  mid;
	logic [twsa_pkg::SLOT_W-1:0]  mid_slot;
	logic [twsa_pkg::TIME_W-1:0]  ram_rdata;
	twsa_pkg::srch_res_t          sres;

	twsa_search u_search (
		.lo    (lo_q),
		.hi    (hi_q),
		.key   (key_q),
		.probe (ram_rdata),
		.mid   (mid),
		.res   (sres)
	);

	// logical index -> ring slot, counting from the oldest held time
	assign mid_slot = twsa_pkg::slot_add(oldest_q, {1'b0, mid});

	// finish-step decode
	logic                          fin_first, fin_append, fin_write, fin_full, fin_clr;
	logic [twsa_pkg::SLOT_W-1:0]   fin_slot;
	logic [twsa_pkg::PROD_W-1:0]   fin_prod;
	twsa_pkg::outcome_t            fin_outcome;
	logic [twsa_pkg::SLOT_W-1:0]   oldest_c;

	assign fin_first  = (held_q == '0);
	assign fin_append = !found_q && (lo_q == held_q);
	assign fin_write  = fin_first || found_q || fin_append;
	assign fin_full   = (held_q == twsa_pkg::CNT_W'(N));
	assign fin_clr    = !fin_first && !found_q && fin_append && fin_full;

	always_comb begin
		if (fin_first)
			fin_slot = newest_q;
		else if (found_q)
			fin_slot = found_slot_q;
		else
			fin_slot = twsa_pkg::slot_add(newest_q, (twsa_pkg::SLOT_W+1)'(1));
	end

	always_comb begin
		if (fin_write)
			fin_outcome = twsa_pkg::OUT_WRITTEN;
		else if (lo_q == '0)
			fin_outcome = twsa_pkg::OUT_LATE;  // older than oldest held time
		else
			fin_outcome = twsa_pkg::OUT_OOO;   // inside the window, not held
	end

	assign fin_prod = twsa_pkg::PROD_W'(fin_slot) * twsa_pkg::PROD_W'(nfreq_q)
		+ twsa_pkg::PROD_W'(freq_q);

	// oldest = newest - (held - 1) mod N, valid while held > 0
	assign oldest_c = twsa_pkg::slot_add(newest_q,
		(twsa_pkg::SLOT_W+1)'(N) - (twsa_pkg::SLOT_W+1)'(held_q - twsa_pkg::CNT_W'(1)));

	// time ring
	twsa_ram #(
		.WIDTH (twsa_pkg::TIME_W),
		.DEPTH (N)
	) u_ring (
		.clk   (clk),
		.we    (out_load && (fin_first || fin_append)),
		.waddr (fin_slot),
		.wdata (key_q),
		.re    (ram_re),
		.raddr (mid_slot),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			twsa_pkg::ST_IDLE: begin
				if (s_axis_tvalid)
					state_d = (held_q == '0) ? twsa_pkg::ST_FINISH : twsa_pkg::ST_ISSUE;
			end
			twsa_pkg::ST_ISSUE: begin
				state_d = twsa_pkg::ST_CMP;
			end
			twsa_pkg::ST_CMP: begin
				state_d = sres.done ? twsa_pkg::ST_FINISH : twsa_pkg::ST_ISSUE;
			end
			twsa_pkg::ST_FINISH: begin
				if (!m_valid_q || m_axis_tready)
					state_d = twsa_pkg::ST_IDLE;
			end
			default: state_d = twsa_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_take  = 1'b0;
		ram_re   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			twsa_pkg::ST_IDLE:   in_take  = 1'b1;
			twsa_pkg::ST_ISSUE:  ram_re   = 1'b1;
			twsa_pkg::ST_CMP:    ram_re   = 1'b0;
			twsa_pkg::ST_FINISH: out_load = !m_valid_q || m_axis_tready;
			default: begin
				in_take  = 1'b0;
				ram_re   = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	assign s_axis_tready = in_take;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= twsa_pkg::ST_IDLE;
			held_q    <= '0;
			newest_q  <= '0;
			wcnt_q    <= '0;
			nfreq_q   <= twsa_pkg::NFREQ_RST;
			m_valid_q <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				nfreq_q <= cfg_wdata;
			if (in_take && s_axis_tvalid)
				found_q <= 1'b0;
			else if (state_q == twsa_pkg::ST_CMP && sres.eq)
				found_q <= 1'b1;
			if (out_load) begin
				m_valid_q <= 1'b1;
				if (fin_write)
					wcnt_q <= wcnt_q + twsa_pkg::WCNT_W'(1);
				if (fin_first) begin
					held_q <= twsa_pkg::CNT_W'(1);
				end else if (!found_q && fin_append) begin
					newest_q <= fin_slot;
					if (!fin_full)
						held_q <= held_q + twsa_pkg::CNT_W'(1);
				end
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take && s_axis_tvalid) begin
			key_q    <= s_axis_tdata[twsa_pkg::TIME_W-1:0];
			freq_q   <= s_axis_tdata[twsa_pkg::TIME_W +: twsa_pkg::FREQ_W];
			seq_q    <= s_axis_tdata[twsa_pkg::TIME_W+twsa_pkg::FREQ_W +: twsa_pkg::SEQ_W];
			lo_q     <= '0;
			hi_q     <= held_q;
			oldest_q <= oldest_c;
		end
		if (ram_re)
			probe_slot_q <= mid_slot;
		if (state_q == twsa_pkg::ST_CMP) begin
			if (sres.eq)
				found_slot_q <= probe_slot_q;
			else begin
				lo_q <= sres.next_lo;
				hi_q <= sres.next_hi;
			end
		end
		if (out_load) begin
			o_outcome_q <= fin_outcome;
			if (fin_write) begin
				o_slot_q <= twsa_pkg::SLOT_O_W'(fin_slot);
				o_addr_q <= fin_prod[twsa_pkg::ADDR_W-1:0];
				o_val_q  <= seq_q;
				o_clr_q  <= fin_clr;
				o_wcnt_q <= wcnt_q + twsa_pkg::WCNT_W'(1);
			end else begin
				o_slot_q <= '0;
				o_addr_q <= '0;
				o_val_q  <= '0;
				o_clr_q  <= 1'b0;
				o_wcnt_q <= wcnt_q;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = o_outcome_q;
	assign m_axis_tdata  = twsa_pkg::OUT_W'({o_wcnt_q, o_clr_q, o_val_q, o_addr_q, o_slot_q});

	`TWSA_ASSERT_NOW(a_held_bound, 1'b1, held_q <= twsa_pkg::CNT_W'(N),
		"held count above ring size")
	`TWSA_ASSERT_NOW(a_window_open, state_q == twsa_pkg::ST_CMP, lo_q < hi_q,
		"probe with empty search window")
	`TWSA_ASSERT_NOW(a_clear_full, out_load && fin_clr, fin_full && !found_q,
		"slot cleared while ring not full")
	`TWSA_ASSERT_NEXT(a_wcnt_step, out_load && fin_write,
		wcnt_q == $past(wcnt_q) + twsa_pkg::WCNT_W'(1), "write count did not advance")

endmodule

### src/twsa_ram.sv
module twsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/twsa_search.sv
// One binary-search probe: compare key with the probed time, narrow [lo, hi).
module twsa_search (
	input  logic [twsa_pkg::CNT_W-1:0]  lo,
	input  logic [twsa_pkg::CNT_W-1:0]  hi,
	input  logic [twsa_pkg::TIME_W-1:0] key,
	input  logic [twsa_pkg::TIME_W-1:0] probe,
	output logic [twsa_pkg::SLOT_W-1:0] mid,
	output twsa_pkg::srch_res_t         res
);

	logic [twsa_pkg::CNT_W:0]   sum;
	logic [twsa_pkg::CNT_W-1:0] mid_c;

	assign sum   = {1'b0, lo} + {1'b0, hi};
	assign mid_c = sum[twsa_pkg::CNT_W:1];
	assign mid   = mid_c[twsa_pkg::SLOT_W-1:0];

	always_comb begin
		res.eq      = (probe == key);
		res.lt      = (probe < key);
		res.next_lo = res.lt ? (mid_c + twsa_pkg::CNT_W'(1)) : lo;
		res.next_hi = (!res.lt && !res.eq) ? mid_c : hi;
		res.done    = res.eq || (res.next_lo == res.next_hi);
	end

endmodule
